// ===== hdl/sorted_list_insert_delete_defines.svh =====
// Assertion macros used by the datapath of the sorted list block.
`ifndef SORTED_LIST_INSERT_DELETE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define SLI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that cons holds in the cycle after ante.
`define SLI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/sli_pkg.sv =====
package sli_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam int VALUE_W    = 32;
	localparam int ELEM_W     = 32;
	localparam int POS_W      = 4;
	localparam int COUNT_W    = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} sli_code_t;

	typedef struct packed {
		logic start;
		logic upd;
		logic eload;
		logic eadv;
	} sli_cmd_t;

	typedef struct packed {
		logic refuse;
		logic upd_last;
		logic empty;
		logic elast;
	} sli_stat_t;

endpackage

// ===== hdl/sli_if.sv =====
interface sli_op_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic signed [sli_pkg::VALUE_W-1:0]  value;

	modport source(output valid, kind, value, input ready);
	modport sink(input valid, kind, value, output ready);
endinterface

interface sli_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [sli_pkg::ELEM_W-1:0]   element;
	logic                                has_element;
	logic [sli_pkg::POS_W-1:0]           position;
	logic [sli_pkg::COUNT_W-1:0]         count;
	logic [1:0]                          status;
	logic                                last;

	modport source(output valid, element, has_element, position, count, status, last,
		input ready);
	modport sink(input valid, element, has_element, position, count, status, last,
		output ready);
endinterface

// ===== hdl/sli_datapath.sv =====
`include "sorted_list_insert_delete_defines.svh"

module sli_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sli_pkg::sli_cmd_t                   cmd,
	output sli_pkg::sli_stat_t                  st,
	input  logic                                kind,
	input  logic signed [sli_pkg::VALUE_W-1:0]  value,
	output logic signed [sli_pkg::ELEM_W-1:0]   element,
	output logic                                has_element,
	output logic [sli_pkg::POS_W-1:0]           position,
	output logic [sli_pkg::COUNT_W-1:0]         count,
	output logic [1:0]                          status,
	output logic                                last
);
	import sli_pkg::*;

	logic [DATA_WIDTH-1:0] mem_q [DEPTH];

	logic                  kind_q;
	logic [DATA_WIDTH-1:0] val_q;
	sli_code_t             stat_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      ridx_q;
	logic [CNT_W-1:0]      pidx_q;
	logic [CNT_W-1:0]      wcnt_q;
	logic                  placed_q;
	logic [DATA_WIDTH-1:0] held_q;
	logic                  pv_q;
	logic [DATA_WIDTH-1:0] rd_q;
	logic [IDX_W-1:0]      eidx_q;

	logic [CNT_W-1:0]      steps;
	logic                  upd_rd;
	logic                  rd_en;
	logic [IDX_W-1:0]      raddr;
	logic                  proc;
	logic                  step_last;
	logic                  ins_here;
	logic                  keep;
	logic                  we;
	logic [IDX_W-1:0]      waddr;
	logic [DATA_WIDTH-1:0] wdata;
	logic                  showing;
	sli_code_t             start_code;

	always_comb begin
		steps     = (kind_q == OP_DELETE) ? n_q : n_q + CNT_W'(1);
		upd_rd    = cmd.upd && (ridx_q < steps);
		rd_en     = upd_rd || cmd.eload || cmd.eadv;
		raddr     = cmd.eload ? '0 : (cmd.eadv ? eidx_q + IDX_W'(1) : ridx_q[IDX_W-1:0]);
		proc      = cmd.upd && pv_q;
		step_last = proc && (pidx_q == steps - CNT_W'(1));
		ins_here  = !placed_q && ((pidx_q == n_q) || ($signed(rd_q) >= $signed(val_q)));
		keep      = (rd_q != val_q);
		if (kind_q == OP_INSERT) begin
			we    = proc && (placed_q || ins_here);
			waddr = pidx_q[IDX_W-1:0];
			wdata = placed_q ? held_q : val_q;
		end else begin
			we    = proc && keep;
			waddr = wcnt_q[IDX_W-1:0];
			wdata = rd_q;
		end
		if (kind == OP_INSERT && n_q == CNT_W'(DEPTH)) begin
			start_code = ST_FULL;
		end else if (kind == OP_DELETE && n_q == '0) begin
			start_code = ST_EMPTY;
		end else begin
			start_code = ST_DONE;
		end
	end

	assign st.refuse   = (start_code != ST_DONE);
	assign st.upd_last = step_last;
	assign st.empty    = (n_q == '0);
	assign st.elast    = (CNT_W'(eidx_q) == n_q - CNT_W'(1));

	assign showing     = (stat_q == ST_DONE) && (n_q != '0);
	assign has_element = showing;
	assign element     = showing ? ELEM_W'($signed(rd_q)) : '0;
	assign position    = showing ? POS_W'(eidx_q) : '0;
	assign count       = COUNT_W'(n_q);
	assign status      = stat_q;
	assign last        = showing ? st.elast : 1'b1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q   <= OP_INSERT;
			val_q    <= '0;
			stat_q   <= ST_DONE;
			n_q      <= '0;
			ridx_q   <= '0;
			pidx_q   <= '0;
			wcnt_q   <= '0;
			placed_q <= 1'b0;
			held_q   <= '0;
			pv_q     <= 1'b0;
			eidx_q   <= '0;
		end else begin
			pv_q <= upd_rd;
			if (cmd.start) begin
				kind_q   <= kind;
				val_q    <= value[DATA_WIDTH-1:0];
				stat_q   <= start_code;
				ridx_q   <= '0;
				pidx_q   <= '0;
				wcnt_q   <= '0;
				placed_q <= 1'b0;
			end
			if (upd_rd) begin
				ridx_q <= ridx_q + CNT_W'(1);
			end
			if (proc) begin
				pidx_q <= pidx_q + CNT_W'(1);
				if (kind_q == OP_INSERT) begin
					if (placed_q || ins_here) begin
						held_q <= rd_q;
					end
					if (ins_here) begin
						placed_q <= 1'b1;
					end
				end else if (keep) begin
					wcnt_q <= wcnt_q + CNT_W'(1);
				end
			end
			if (step_last) begin
				if (kind_q == OP_INSERT) begin
					n_q <= n_q + CNT_W'(1);
				end else begin
					n_q <= wcnt_q + CNT_W'(keep);
				end
			end
			if (cmd.eload) begin
				eidx_q <= '0;
			end else if (cmd.eadv) begin
				eidx_q <= eidx_q + IDX_W'(1);
			end
		end
	end

	`SLI_ASSERT_NOW(a_count_bound, 1'b1, n_q <= CNT_W'(DEPTH), "Entry count exceeds depth.")
	`SLI_ASSERT_NOW(a_write_behind_read, we, CNT_W'(waddr) < ridx_q, "Write overtakes the read pointer.")
	`SLI_ASSERT_NEXT(a_insert_grows, step_last && kind_q == OP_INSERT, n_q == $past(n_q) + CNT_W'(1), "Insert did not add one entry.")
	`SLI_ASSERT_NEXT(a_delete_shrinks, step_last && kind_q == OP_DELETE, n_q <= $past(n_q), "Delete grew the list.")
	`SLI_ASSERT_NOW(a_advance_in_range, cmd.eadv, CNT_W'(eidx_q) + CNT_W'(1) < n_q, "Output advanced past the last entry.")

endmodule

// ===== hdl/sli_ctrl.sv =====
module sli_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               op_valid,
	output logic               op_ready,
	output logic               res_valid,
	input  logic               res_ready,
	output sli_pkg::sli_cmd_t  cmd,
	input  sli_pkg::sli_stat_t st
);
	import sli_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UPD,
		S_LOAD,
		S_SHOW,
		S_NOTE
	} state_t;

	state_t state_q;

	assign op_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_SHOW) || (state_q == S_NOTE);

	always_comb begin
		cmd.start = (state_q == S_IDLE) && op_valid;
		cmd.upd   = (state_q == S_UPD);
		cmd.eload = (state_q == S_LOAD) && !st.empty;
		cmd.eadv  = (state_q == S_SHOW) && res_ready && !st.elast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (op_valid) begin
						state_q <= st.refuse ? S_NOTE : S_UPD;
					end
				end
				S_UPD: begin
					if (st.upd_last) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= st.empty ? S_NOTE : S_SHOW;
				end
				S_SHOW: begin
					if (res_ready && st.elast) begin
						state_q <= S_IDLE;
					end
				end
				S_NOTE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/sorted_list_insert_delete.sv =====
// Keeps up to 16 signed 32-bit entries in ascending order in a register file with one read
// and one write port.
// Each accepted word (insert or delete) is followed by an update pass over the stored list,
// one entry per cycle through a registered read, then a load state, then the new list is
// sent in ascending order, one entry per cycle while the receiver is ready, with the final
// word flagged; an empty list or a refused operation (insert into a full list, delete on an
// empty list) sends a single word with no element. A new word is accepted only after the
// last result word of the previous one has been taken.
module sorted_list_insert_delete (
	input  logic       clk,
	input  logic       arst_n,
	sli_op_if.sink     op,
	sli_res_if.source  res
);
	import sli_pkg::*;

	sli_cmd_t  cmd;
	sli_stat_t st;

	sli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op.valid),
		.op_ready  (op.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.cmd       (cmd),
		.st        (st)
	);

	sli_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.kind        (op.kind),
		.value       (op.value),
		.element     (res.element),
		.has_element (res.has_element),
		.position    (res.position),
		.count       (res.count),
		.status      (res.status),
		.last        (res.last)
	);

endmodule

// ===== tb/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sli_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_OPS  = 425;
	localparam int CALM_OPS    = 50;
	localparam int DRAIN_WAIT  = 2 * DEPTH + 8;

	localparam logic signed [VALUE_W-1:0] V_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] V_MAX = 32'sh7fff_ffff;

	typedef struct packed {
		logic signed [ELEM_W-1:0] element;
		logic                     has_element;
		logic [POS_W-1:0]         position;
		logic [COUNT_W-1:0]       count;
		sli_code_t                status;
		logic                     last;
	} list_word_t;

	typedef struct packed {
		logic                      kind;
		logic signed [VALUE_W-1:0] value;
		logic                      typed;
		list_word_t                word;
	} stim_row_t;

	logic clk;
	logic arst_n;

	sli_op_if  op_bus();
	sli_res_if res_bus();

	sorted_list_insert_delete dut (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_bus),
		.res    (res_bus)
	);

	logic signed [ELEM_W-1:0] list_entries[$];
	list_word_t               list_words_due[$];
	int                       fault_count;
	int                       cycle_count;
	bit                       calm;
	int                       op_gap_pct;

	// Rows with a typed word expect exactly that single word back.
	stim_row_t dir_rows [0:24] = '{
		'{OP_DELETE, 32'sd5, 1'b1, '{32'sd0, 1'b0, 4'd0, 5'd0, ST_EMPTY, 1'b1}},
		'{OP_INSERT, V_MIN, 1'b1, '{V_MIN, 1'b1, 4'd0, 5'd1, ST_DONE, 1'b1}},
		'{OP_DELETE, V_MIN, 1'b1, '{32'sd0, 1'b0, 4'd0, 5'd0, ST_DONE, 1'b1}},
		'{OP_INSERT, V_MAX, 1'b1, '{V_MAX, 1'b1, 4'd0, 5'd1, ST_DONE, 1'b1}},
		'{OP_INSERT, V_MIN, 1'b0, '0},
		'{OP_INSERT, 32'sd0, 1'b0, '0},
		'{OP_INSERT, -32'sd1, 1'b0, '0},
		'{OP_INSERT, 32'sd0, 1'b0, '0},
		'{OP_INSERT, 32'sd1, 1'b0, '0},
		'{OP_DELETE, 32'sd12345, 1'b0, '0},
		'{OP_DELETE, 32'sd0, 1'b0, '0},
		'{OP_INSERT, V_MAX, 1'b0, '0},
		'{OP_INSERT, V_MIN, 1'b0, '0},
		'{OP_INSERT, 32'sh5555_5555, 1'b0, '0},
		'{OP_INSERT, 32'shaaaa_aaaa, 1'b0, '0},
		'{OP_INSERT, 32'sd100, 1'b0, '0},
		'{OP_INSERT, -32'sd100, 1'b0, '0},
		'{OP_INSERT, 32'sd100, 1'b0, '0},
		'{OP_INSERT, 32'sd2, 1'b0, '0},
		'{OP_INSERT, 32'sd3, 1'b0, '0},
		'{OP_INSERT, -32'sd2, 1'b0, '0},
		'{OP_INSERT, 32'sh7fff_fffe, 1'b0, '0},
		'{OP_INSERT, 32'sh8000_0001, 1'b0, '0},
		'{OP_INSERT, 32'sd7, 1'b1, '{32'sd0, 1'b0, 4'd0, 5'd16, ST_FULL, 1'b1}},
		'{OP_DELETE, V_MAX, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
	end

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic list_word_t make_word(input logic signed [ELEM_W-1:0] elem,
		input logic has, input int pos, input int cnt, input sli_code_t code, input logic fin);
		list_word_t w;
		w.element     = elem;
		w.has_element = has;
		w.position    = POS_W'(pos);
		w.count       = COUNT_W'(cnt);
		w.status      = code;
		w.last        = fin;
		return w;
	endfunction

	// Applies one operation to the local copy of the list and returns the words it causes.
	function automatic void apply_list_op(input logic k, input logic signed [VALUE_W-1:0] v,
		output list_word_t words[$]);
		int                       at;
		logic signed [ELEM_W-1:0] kept[$];
		words = {};
		if (k == OP_INSERT) begin
			if (list_entries.size() >= DEPTH) begin
				words.push_back(make_word('0, 1'b0, 0, DEPTH, ST_FULL, 1'b1));
				return;
			end
			at = list_entries.size();
			for (int i = 0; i < list_entries.size(); i++) begin
				if (list_entries[i] >= v) begin
					at = i;
					break;
				end
			end
			list_entries.insert(at, v);
		end else begin
			if (list_entries.size() == 0) begin
				words.push_back(make_word('0, 1'b0, 0, 0, ST_EMPTY, 1'b1));
				return;
			end
			foreach (list_entries[i]) begin
				if (list_entries[i] != v)
					kept.push_back(list_entries[i]);
			end
			list_entries = kept;
		end
		if (list_entries.size() == 0) begin
			words.push_back(make_word('0, 1'b0, 0, 0, ST_DONE, 1'b1));
		end else begin
			foreach (list_entries[i])
				words.push_back(make_word(list_entries[i], 1'b1, i, list_entries.size(), ST_DONE,
					i == list_entries.size() - 1));
		end
	endfunction

	function automatic logic signed [VALUE_W-1:0] pick_value(input logic k);
		int r;
		r = $urandom_range(0, 99);
		if (list_entries.size() != 0 && (r < 20 || (k == OP_DELETE && r < 60)))
			return list_entries[$urandom_range(0, list_entries.size() - 1)];
		if (r < 65)
			return VALUE_W'($urandom_range(0, 15)) - VALUE_W'(8);
		if (r < 80) begin
			case ($urandom_range(0, 3))
				0: return V_MIN;
				1: return V_MAX;
				2: return V_MIN + 1;
				default: return V_MAX - 1;
			endcase
		end
		return $urandom;
	endfunction

	// Entered and left at a falling edge.
	task automatic send_op(input logic k, input logic signed [VALUE_W-1:0] v,
		input logic typed, input list_word_t typed_word);
		list_word_t words[$];
		if (!calm && $urandom_range(0, 99) < op_gap_pct) begin
			op_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		op_bus.valid <= 1'b1;
		op_bus.kind  <= k;
		op_bus.value <= v;
		@(posedge clk);
		while (op_bus.ready !== 1'b1)
			@(posedge clk);
		apply_list_op(k, v, words);
		if (typed)
			list_words_due.push_back(typed_word);
		else
			foreach (words[i])
				list_words_due.push_back(words[i]);
		@(negedge clk);
	endtask

	task automatic wait_list_drained();
		op_bus.valid <= 1'b0;
		while (list_words_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int  insert_pct;
		logic k;
		arst_n         = 1'b0;
		op_bus.valid   = 1'b0;
		op_bus.kind    = OP_INSERT;
		op_bus.value   = '0;
		fault_count    = 0;
		calm           = 1'b0;
		op_gap_pct     = 20;
		insert_pct     = 55;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_op(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].word);

		// The sender holds off here until the list has been sent back in full.
		wait_list_drained();

		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: insert_pct = 25;
					1: insert_pct = 55;
					default: insert_pct = 85;
				endcase
			end
			if (n % 50 == 0) begin
				case ($urandom_range(0, 2))
					0: op_gap_pct = 0;
					1: op_gap_pct = 15;
					default: op_gap_pct = 40;
				endcase
			end
			if (n == RANDOM_OPS - CALM_OPS)
				calm = 1'b1;
			k = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
			send_op(k, pick_value(k), 1'b0, '0);
		end

		wait_list_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fault_count == 0)
			$display("sorted_list_insert_delete regression: pass");
		else
			$display("sorted_list_insert_delete regression: fail");
		$finish;
	end

	initial begin
		int stall_left;
		int stall_pct;
		int ticks;
		stall_left    = 0;
		stall_pct     = 0;
		ticks         = 0;
		res_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			ticks++;
			if (ticks % 200 == 0) begin
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 30;
				endcase
			end
			if (stall_left == 0 && !calm && $urandom_range(0, 99) < stall_pct)
				stall_left = $urandom_range(1, 16);
			if (stall_left > 0) begin
				res_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				res_bus.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		list_word_t exp_word;
		if (arst_n && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
			if (list_words_due.size() == 0) begin
				$error("unexpected word: element %0d, status %0d", res_bus.element, res_bus.status);
				fault_count++;
			end else begin
				exp_word = list_words_due.pop_front();
				if (res_bus.element !== exp_word.element) begin
					$error("element: expected %0d, got %0d", exp_word.element, res_bus.element);
					fault_count++;
				end
				if (res_bus.has_element !== exp_word.has_element) begin
					$error("has_element: expected %0d, got %0d", exp_word.has_element,
						res_bus.has_element);
					fault_count++;
				end
				if (res_bus.position !== exp_word.position) begin
					$error("position: expected %0d, got %0d", exp_word.position, res_bus.position);
					fault_count++;
				end
				if (res_bus.count !== exp_word.count) begin
					$error("count: expected %0d, got %0d", exp_word.count, res_bus.count);
					fault_count++;
				end
				if (res_bus.status !== exp_word.status) begin
					$error("status: expected %0d, got %0d", exp_word.status, res_bus.status);
					fault_count++;
				end
				if (res_bus.last !== exp_word.last) begin
					$error("last: expected %0d, got %0d", exp_word.last, res_bus.last);
					fault_count++;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("sorted_list_insert_delete regression: fail");
			$finish;
		end
	end

endmodule
